// ----- hw/rtl/lpmc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpmc_pkg
// Shared types and constants of the line pattern match counter.
// ----------------------------------------------------------------------------
package lpmc_pkg;

   localparam int PATTERN_MAX_DEF = 32;
   localparam int LINE_MAX_DEF    = 1024;

   localparam int CHAR_W       = 8;
   localparam int COUNT_W      = 10;
   localparam int OUT_POS_W    = 10;
   localparam int TOTAL_W      = 32;
   localparam int LENGTH_W     = 6;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_ADDR_W   = 6;
   localparam int CSR_INDEX_LO = 3;
   localparam int PAT_REG_COUNT = 4;
   localparam int PAT_REG_CHARS = PAT_REG_COUNT * (CSR_DATA_W / CHAR_W);

   localparam logic [CHAR_W-1:0]   CHAR_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_W-1:0]   CHAR_PIPE       = 8'h7C;
   localparam logic [COUNT_W-1:0]  COUNT_MAX       = 10'd1023;
   localparam logic [LENGTH_W-1:0] LENGTH_RESET    = 6'd1;

   typedef enum logic [CSR_ADDR_W-CSR_INDEX_LO-1:0] {
      REG_PATTERN_LENGTH  = 3'd0,
      REG_PATTERN_CHARS_0 = 3'd1,
      REG_PATTERN_CHARS_1 = 3'd2,
      REG_PATTERN_CHARS_2 = 3'd3,
      REG_PATTERN_CHARS_3 = 3'd4
   } csr_reg_type;

   // control handed from the window stage to the tally stage
   typedef struct packed {
      logic valid;
      logic last;
      logic hit;
   } stage_word_type;

endpackage

// ----- hw/rtl/line_pattern_match_counter.sv -----
// An accepted word sits in the window stage; when it advances, the tally logic
// behind it loads the line result into the result register, where rsp_valid
// rises.
// Throughput: one character word per cycle, sustained, across line boundaries;
// only a held result with rsp_stall high and a line end behind it stops intake.
// Reset (synchronous): pattern length to one, pattern characters to zero, line
// state and running total cleared; no clearing pass.
// ----------------------------------------------------------------------------
// line_pattern_match_counter
// Exact pattern counting over text lines, with header marker positions.
// ----------------------------------------------------------------------------
module line_pattern_match_counter #(
   parameter int PATTERN_MAX = lpmc_pkg::PATTERN_MAX_DEF,
   parameter int LINE_MAX    = lpmc_pkg::LINE_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // character words in
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lpmc_pkg::CHAR_W-1:0]         req_char_in,
   input  logic                                req_line_end,
   // line results out
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lpmc_pkg::COUNT_W-1:0]        rsp_line_matches,
   output logic                                rsp_header_ok,
   output logic [lpmc_pkg::OUT_POS_W-1:0]      rsp_underscore_pos,
   output logic [lpmc_pkg::OUT_POS_W-1:0]      rsp_pipe_pos,
   output logic [lpmc_pkg::TOTAL_W-1:0]        rsp_total_matches,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lpmc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lpmc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lpmc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int POS_W = $clog2(LINE_MAX);
   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int CMP_W = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_MAX - 1);

   logic [LEN_W-1:0]                              eff_len;
   logic [PATTERN_MAX-1:0][lpmc_pkg::CHAR_W-1:0]  aligned_pattern;
   logic [PATTERN_MAX-1:0]                        slot_in_use;

   // window stage
   logic [PATTERN_MAX-1:0][lpmc_pkg::CHAR_W-1:0]  win_ff, win_in;
   logic [POS_W-1:0]                              pos_ff, pos_in;
   logic [POS_W-1:0]                              a_pos_ff;
   logic                                          a_last_ff;
   logic                                          a_reached_ff, a_reached_in;
   logic                                          a_valid_ff, a_valid_in;
   logic                                          accept;
   logic                                          advance;
   logic                                          window_hit;
   lpmc_pkg::stage_word_type                      word;

   lpmc_csr #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .eff_len         (eff_len),
      .aligned_pattern (aligned_pattern),
      .slot_in_use     (slot_in_use)
   );

   // Advance the window word into the tally unless it ends a line and the
   // result register is still held by a stalled result.
   assign advance   = a_valid_ff && (!a_last_ff || !rsp_valid || !rsp_stall);
   assign req_stall = a_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // Shift the new character in at slot 0. Stale bytes from an earlier line
   // are left in place: the length-reached flag keeps them out of any match.
   always_comb begin
      win_in[0] = req_char_in;
      for (int i = 1; i < PATTERN_MAX; i++) begin
         win_in[i] = win_ff[i-1];
      end
   end

   // Hold the offset at the line limit once it gets there; restart per line.
   always_comb begin
      if (req_line_end) begin
         pos_in = '0;
      end else if (pos_ff < POS_LAST) begin
         pos_in = pos_ff + 1'b1;
      end else begin
         pos_in = pos_ff;
      end
      a_reached_in = (CMP_W'(pos_ff) + CMP_W'(1)) >= CMP_W'(eff_len);
   end

   always_comb begin
      if (accept) begin
         a_valid_in = 1'b1;
      end else begin
         a_valid_in = a_valid_ff && !advance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (accept) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff       <= win_in;
         a_pos_ff     <= pos_ff;
         a_last_ff    <= req_line_end;
         a_reached_ff <= a_reached_in;
      end
   end

   // Compare every slot in use against the pre-aligned pattern at once.
   always_comb begin
      window_hit = a_reached_ff;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (slot_in_use[i] && (win_ff[i] != aligned_pattern[i])) begin
            window_hit = 1'b0;
         end
      end
   end

   assign word.valid = advance;
   assign word.last  = a_last_ff;
   assign word.hit   = window_hit;

   lpmc_tally #(
      .POS_W (POS_W)
   ) u_tally (
      .clock              (clock),
      .reset              (reset),
      .word               (word),
      .char_cur           (win_ff[0]),
      .pos_cur            (a_pos_ff),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_line_matches   (rsp_line_matches),
      .rsp_header_ok      (rsp_header_ok),
      .rsp_underscore_pos (rsp_underscore_pos),
      .rsp_pipe_pos       (rsp_pipe_pos),
      .rsp_total_matches  (rsp_total_matches)
   );

endmodule

// ----- hw/rtl/lpmc_csr.sv -----
// ----------------------------------------------------------------------------
// lpmc_csr
// Pattern registers behind the APB-style port, plus the pattern laid out
// against the character window (newest character at slot 0).
// ----------------------------------------------------------------------------
module lpmc_csr #(
   parameter int PATTERN_MAX = lpmc_pkg::PATTERN_MAX_DEF,
   localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [lpmc_pkg::CSR_ADDR_W-1:0]           csr_paddr,
   input  logic [lpmc_pkg::CSR_DATA_W-1:0]           csr_pwdata,
   output logic [lpmc_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                      csr_pready,
   output logic [LEN_W-1:0]                          eff_len,
   output logic [PATTERN_MAX-1:0][lpmc_pkg::CHAR_W-1:0] aligned_pattern,
   output logic [PATTERN_MAX-1:0]                    slot_in_use
);

   logic [lpmc_pkg::LENGTH_W-1:0] length_ff;
   logic [lpmc_pkg::PAT_REG_COUNT-1:0][lpmc_pkg::CSR_DATA_W-1:0] chars_ff;
   logic [PATTERN_MAX-1:0][lpmc_pkg::CHAR_W-1:0] aligned_ff, aligned_in;
   logic [PATTERN_MAX-1:0] use_ff, use_in;
   lpmc_pkg::csr_reg_type  reg_sel;
   logic                   wr_en;
   logic [7:0]             len_wide;
   logic [7:0]             len_eff_wide;

   assign reg_sel    = lpmc_pkg::csr_reg_type'(
                          csr_paddr[lpmc_pkg::CSR_ADDR_W-1:lpmc_pkg::CSR_INDEX_LO]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= lpmc_pkg::LENGTH_RESET;
         chars_ff  <= '0;
      end else if (wr_en) begin
         case (reg_sel)
            lpmc_pkg::REG_PATTERN_LENGTH:  length_ff   <= csr_pwdata[lpmc_pkg::LENGTH_W-1:0];
            lpmc_pkg::REG_PATTERN_CHARS_0: chars_ff[0] <= csr_pwdata;
            lpmc_pkg::REG_PATTERN_CHARS_1: chars_ff[1] <= csr_pwdata;
            lpmc_pkg::REG_PATTERN_CHARS_2: chars_ff[2] <= csr_pwdata;
            lpmc_pkg::REG_PATTERN_CHARS_3: chars_ff[3] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         lpmc_pkg::REG_PATTERN_LENGTH:  csr_prdata = lpmc_pkg::CSR_DATA_W'(length_ff);
         lpmc_pkg::REG_PATTERN_CHARS_0: csr_prdata = chars_ff[0];
         lpmc_pkg::REG_PATTERN_CHARS_1: csr_prdata = chars_ff[1];
         lpmc_pkg::REG_PATTERN_CHARS_2: csr_prdata = chars_ff[2];
         lpmc_pkg::REG_PATTERN_CHARS_3: csr_prdata = chars_ff[3];
         default:                       csr_prdata = '0;
      endcase
   end

   // zero length counts as one, anything above the window as the window
   always_comb begin
      len_wide = 8'(length_ff);
      if (len_wide == 8'd0) begin
         len_eff_wide = 8'd1;
      end else if (len_wide > 8'(PATTERN_MAX)) begin
         len_eff_wide = 8'(PATTERN_MAX);
      end else begin
         len_eff_wide = len_wide;
      end
   end

   assign eff_len = LEN_W'(len_eff_wide);

   // window slot i holds the character that must equal pattern char len-1-i
   always_comb begin
      int k;
      logic [lpmc_pkg::PAT_REG_CHARS*lpmc_pkg::CHAR_W-1:0] flat;
      flat = chars_ff;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         k = int'(eff_len) - 1 - i;
         use_in[i] = (LEN_W'(i) < eff_len);
         if (k >= 0 && k < lpmc_pkg::PAT_REG_CHARS) begin
            aligned_in[i] = flat[8'(k)*lpmc_pkg::CHAR_W +: lpmc_pkg::CHAR_W];
         end else begin
            aligned_in[i] = '0;
         end
      end
   end

   // config is quasi-static: register the layout off the match path
   always_ff @(posedge clock) begin
      aligned_ff <= aligned_in;
      use_ff     <= use_in;
   end

   assign aligned_pattern = aligned_ff;
   assign slot_in_use     = use_ff;

endmodule

// ----- hw/rtl/lpmc_tally.sv -----
// ----------------------------------------------------------------------------
// lpmc_tally
// Per-line match count, header marker tracking, running total and the
// result register.
// ----------------------------------------------------------------------------
module lpmc_tally #(
   parameter int POS_W = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lpmc_pkg::stage_word_type           word,
   input  logic [lpmc_pkg::CHAR_W-1:0]        char_cur,
   input  logic [POS_W-1:0]                   pos_cur,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [lpmc_pkg::COUNT_W-1:0]       rsp_line_matches,
   output logic                               rsp_header_ok,
   output logic [lpmc_pkg::OUT_POS_W-1:0]     rsp_underscore_pos,
   output logic [lpmc_pkg::OUT_POS_W-1:0]     rsp_pipe_pos,
   output logic [lpmc_pkg::TOTAL_W-1:0]       rsp_total_matches
);

   logic [lpmc_pkg::COUNT_W-1:0] raw_ff, raw_in;
   logic                         us_seen_ff, us_seen_in;
   logic [POS_W-1:0]             us_ofs_ff, us_ofs_in;
   logic                         pp_seen_ff, pp_seen_in;
   logic [POS_W-1:0]             pp_ofs_ff, pp_ofs_in;
   logic [lpmc_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lpmc_pkg::COUNT_W-1:0] lm_ff, lm_in;
   logic                         ok_ff, ok_in;
   logic [lpmc_pkg::OUT_POS_W-1:0] us_out_ff, us_out_in, pp_out_ff, pp_out_in;
   logic [lpmc_pkg::TOTAL_W:0]   total_sum;
   logic [31:0]                  us_wide, pp_wide;
   logic                         emit;

   assign emit = word.valid && word.last;

   always_comb begin
      us_seen_in = us_seen_ff;
      us_ofs_in  = us_ofs_ff;
      pp_seen_in = pp_seen_ff;
      pp_ofs_in  = pp_ofs_ff;
      raw_in     = raw_ff;
      if (char_cur == lpmc_pkg::CHAR_UNDERSCORE && !us_seen_ff) begin
         us_seen_in = 1'b1;
         us_ofs_in  = pos_cur;
      end
      if (char_cur == lpmc_pkg::CHAR_PIPE && !pp_seen_ff) begin
         pp_seen_in = 1'b1;
         pp_ofs_in  = pos_cur;
      end
      if (word.hit && raw_ff < lpmc_pkg::COUNT_MAX) begin
         raw_in = raw_ff + 1'b1;
      end
   end

   always_comb begin
      ok_in     = us_seen_in && pp_seen_in && (us_ofs_in < pp_ofs_in);
      lm_in     = ok_in ? raw_in : '0;
      us_wide   = 32'(us_ofs_in);
      pp_wide   = 32'(pp_ofs_in);
      us_out_in = ok_in ? us_wide[lpmc_pkg::OUT_POS_W-1:0] : '0;
      pp_out_in = ok_in ? pp_wide[lpmc_pkg::OUT_POS_W-1:0] : '0;
      total_sum = (lpmc_pkg::TOTAL_W+1)'(total_ff) + (lpmc_pkg::TOTAL_W+1)'(lm_in);
      total_in  = total_sum[lpmc_pkg::TOTAL_W] ? '1 : total_sum[lpmc_pkg::TOTAL_W-1:0];
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff       <= '0;
         us_seen_ff   <= 1'b0;
         pp_seen_ff   <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (word.valid) begin
            if (word.last) begin
               raw_ff     <= '0;
               us_seen_ff <= 1'b0;
               pp_seen_ff <= 1'b0;
               total_ff   <= total_in;
            end else begin
               raw_ff     <= raw_in;
               us_seen_ff <= us_seen_in;
               pp_seen_ff <= pp_seen_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (word.valid) begin
         us_ofs_ff <= us_ofs_in;
         pp_ofs_ff <= pp_ofs_in;
      end
      if (emit) begin
         lm_ff     <= lm_in;
         ok_ff     <= ok_in;
         us_out_ff <= us_out_in;
         pp_out_ff <= pp_out_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_matches   = lm_ff;
   assign rsp_header_ok      = ok_ff;
   assign rsp_underscore_pos = us_out_ff;
   assign rsp_pipe_pos       = pp_out_ff;
   assign rsp_total_matches  = total_ff;

endmodule

// ----- verif/line_pattern_match_counter_tb.sv -----
// ----------------------------------------------------------------------------
// line_pattern_match_counter_tb
// Self-checking bench for the line pattern match counter. Text lines go in one
// character word at a time; a scoreboard runs its own copy of the matching,
// header and running-total logic and compares every line result field by field.
// Pattern registers are reprogrammed between phases over the register port.
// ----------------------------------------------------------------------------

class match_count_board;

   typedef struct {
      logic [lpmc_pkg::COUNT_W-1:0]   line_matches;
      logic                           header_ok;
      logic [lpmc_pkg::OUT_POS_W-1:0] underscore_pos;
      logic [lpmc_pkg::OUT_POS_W-1:0] pipe_pos;
      logic [lpmc_pkg::TOTAL_W-1:0]   total_matches;
   } line_result_type;

   line_result_type pending_lines[$];
   int mismatches;

   logic [lpmc_pkg::LENGTH_W-1:0]   length_reg;
   logic [lpmc_pkg::CSR_DATA_W-1:0] chars_reg [lpmc_pkg::PAT_REG_COUNT];

   logic [lpmc_pkg::CHAR_W-1:0] window [lpmc_pkg::PATTERN_MAX_DEF];
   int position;
   int line_count;
   bit underscore_seen;
   bit pipe_seen;
   int underscore_ofs;
   int pipe_ofs;
   logic [lpmc_pkg::TOTAL_W-1:0] grand_total;

   function new();
      length_reg = lpmc_pkg::LENGTH_RESET;
      foreach (chars_reg[r]) chars_reg[r] = '0;
      grand_total = '0;
      mismatches = 0;
      clear_line();
   endfunction

   function void clear_line();
      foreach (window[i]) window[i] = '0;
      position = 0;
      line_count = 0;
      underscore_seen = 1'b0;
      pipe_seen = 1'b0;
      underscore_ofs = 0;
      pipe_ofs = 0;
   endfunction

   // zero reads as one, anything past the window as the full window
   function int eff_len();
      int n;
      n = length_reg;
      if (n == 0) n = 1;
      if (n > lpmc_pkg::PATTERN_MAX_DEF) n = lpmc_pkg::PATTERN_MAX_DEF;
      return n;
   endfunction

   function logic [lpmc_pkg::CHAR_W-1:0] pat_char(int k);
      if (k >= lpmc_pkg::PAT_REG_CHARS) return '0;
      return chars_reg[k / 8][(k % 8) * 8 +: 8];
   endfunction

   function void set_reg(logic [2:0] idx, logic [lpmc_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         lpmc_pkg::REG_PATTERN_LENGTH:  length_reg = value[lpmc_pkg::LENGTH_W-1:0];
         lpmc_pkg::REG_PATTERN_CHARS_0: chars_reg[0] = value;
         lpmc_pkg::REG_PATTERN_CHARS_1: chars_reg[1] = value;
         lpmc_pkg::REG_PATTERN_CHARS_2: chars_reg[2] = value;
         lpmc_pkg::REG_PATTERN_CHARS_3: chars_reg[3] = value;
         default: ;
      endcase
   endfunction

   function logic [lpmc_pkg::CSR_DATA_W-1:0] reg_value(logic [2:0] idx);
      case (idx)
         lpmc_pkg::REG_PATTERN_LENGTH:  return lpmc_pkg::CSR_DATA_W'(length_reg);
         lpmc_pkg::REG_PATTERN_CHARS_0: return chars_reg[0];
         lpmc_pkg::REG_PATTERN_CHARS_1: return chars_reg[1];
         lpmc_pkg::REG_PATTERN_CHARS_2: return chars_reg[2];
         lpmc_pkg::REG_PATTERN_CHARS_3: return chars_reg[3];
         default: return '0;
      endcase
   endfunction

   // advance the line by one character; queue the line result on its last one
   function void take_char(logic [lpmc_pkg::CHAR_W-1:0] c, logic last);
      int len;
      bit hit;
      line_result_type res;
      logic [lpmc_pkg::TOTAL_W:0] sum;
      len = eff_len();
      for (int i = lpmc_pkg::PATTERN_MAX_DEF - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = c;
      if (c == lpmc_pkg::CHAR_UNDERSCORE && !underscore_seen) begin
         underscore_seen = 1'b1;
         underscore_ofs = position;
      end
      if (c == lpmc_pkg::CHAR_PIPE && !pipe_seen) begin
         pipe_seen = 1'b1;
         pipe_ofs = position;
      end
      if (position + 1 >= len) begin
         hit = 1'b1;
         for (int j = 0; j < len; j++)
            if (window[len-1-j] != pat_char(j)) hit = 1'b0;
         if (hit && line_count < lpmc_pkg::COUNT_MAX) line_count++;
      end
      if (position < lpmc_pkg::LINE_MAX_DEF - 1) position++;
      if (!last) return;
      res.header_ok = underscore_seen && pipe_seen && (underscore_ofs < pipe_ofs);
      res.line_matches = res.header_ok ? lpmc_pkg::COUNT_W'(line_count) : '0;
      res.underscore_pos = res.header_ok ? lpmc_pkg::OUT_POS_W'(underscore_ofs) : '0;
      res.pipe_pos = res.header_ok ? lpmc_pkg::OUT_POS_W'(pipe_ofs) : '0;
      sum = grand_total + res.line_matches;
      grand_total = sum[lpmc_pkg::TOTAL_W] ? '1 : sum[lpmc_pkg::TOTAL_W-1:0];
      res.total_matches = grand_total;
      pending_lines.push_back(res);
      clear_line();
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function void check_line(logic [lpmc_pkg::COUNT_W-1:0] line_matches, logic header_ok,
                            logic [lpmc_pkg::OUT_POS_W-1:0] underscore_pos,
                            logic [lpmc_pkg::OUT_POS_W-1:0] pipe_pos,
                            logic [lpmc_pkg::TOTAL_W-1:0] total_matches);
      line_result_type want;
      if (pending_lines.size() == 0) begin
         $error("line result with no line pending");
         mismatches++;
         return;
      end
      want = pending_lines.pop_front();
      compare_field("line_matches", want.line_matches, line_matches);
      compare_field("header_ok", want.header_ok, header_ok);
      compare_field("underscore_pos", want.underscore_pos, underscore_pos);
      compare_field("pipe_pos", want.pipe_pos, pipe_pos);
      compare_field("total_matches", want.total_matches, total_matches);
   endfunction

endclass

module line_pattern_match_counter_tb;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_OFF = 4;          // settle time after the last result
   localparam int PHASES = 12;
   localparam int PHASE_WORDS = 24;      // with the long line, about 1500 words
   localparam logic [2:0] SPARE_REG = 3'd5;
   localparam logic [lpmc_pkg::CHAR_W-1:0] CHAR_FILL = 8'h78;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCK} stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [lpmc_pkg::CHAR_W-1:0]         req_char_in = '0;
   logic                                req_line_end = 1'b0;

   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [lpmc_pkg::COUNT_W-1:0]        rsp_line_matches;
   logic                                rsp_header_ok;
   logic [lpmc_pkg::OUT_POS_W-1:0]      rsp_underscore_pos;
   logic [lpmc_pkg::OUT_POS_W-1:0]      rsp_pipe_pos;
   logic [lpmc_pkg::TOTAL_W-1:0]        rsp_total_matches;

   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [lpmc_pkg::CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [lpmc_pkg::CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [lpmc_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                csr_pready;

   match_count_board board;
   logic [lpmc_pkg::CHAR_W-1:0] line_buf[$];
   int burst_left = 0;
   int reg_mismatches = 0;
   int cycle_count = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int stall_left = 0;

   line_pattern_match_counter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_in        (req_char_in),
      .req_line_end       (req_line_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_line_matches   (rsp_line_matches),
      .rsp_header_ok      (rsp_header_ok),
      .rsp_underscore_pos (rsp_underscore_pos),
      .rsp_pipe_pos       (rsp_pipe_pos),
      .rsp_total_matches  (rsp_total_matches),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: a hung handshake must still end the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Sample both channels at the rising edge, before the block's own updates
   // land. Note the accepted word first so a line result can never overtake it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.take_char(req_char_in, req_line_end);
         if (rsp_valid && !rsp_stall)
            board.check_line(rsp_line_matches, rsp_header_ok, rsp_underscore_pos,
                             rsp_pipe_pos, rsp_total_matches);
      end
   end

   // Result stall: a randomly chosen mode for a random stretch, from a clear path to
   // long solid holds, so that a held result meets every phase of intake.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(10, 80);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall = 1'b0;
         STALL_LIGHT: rsp_stall = ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall = ($urandom_range(0, 1) == 0);
         default:     rsp_stall = ((stall_left % 24) < 14);
      endcase
   end

   // Offer one word and hold it until taken. Bursts of random length, with
   // random gaps between them; a zero gap runs two bursts back to back.
   task automatic put_word(input logic [lpmc_pkg::CHAR_W-1:0] c, input logic last);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 64)
                                                  : $urandom_range(1, 16);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid = 1'b1;
      req_char_in = c;
      req_line_end = last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_line();
      foreach (line_buf[i]) put_word(line_buf[i], i == line_buf.size() - 1);
   endtask

   // Drop valid, let every pending line come back, then allow the pipeline
   // to settle before anything touches the registers.
   task automatic drain_lines();
      @(negedge clock);
      req_valid = 1'b0;
      burst_left = 0;
      while (board.pending_lines.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx,
                            input logic [lpmc_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = lpmc_pkg::CSR_ADDR_W'(idx) << lpmc_pkg::CSR_INDEX_LO;
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.set_reg(idx, value);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic csr_check(input lpmc_pkg::csr_reg_type idx);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = lpmc_pkg::CSR_ADDR_W'(idx) << lpmc_pkg::CSR_INDEX_LO;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== board.reg_value(idx)) begin
         $error("%s: expected %0h, got %0h", idx.name(), board.reg_value(idx), csr_prdata);
         reg_mismatches++;
      end
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Build one line of n characters. Most lines are text over a two-symbol
   // alphabet with whole and nearly whole pattern copies, plus a header mark
   // pair placed early; the rest are raw noise or have broken headers.
   task automatic compose_line(input int n, input logic [lpmc_pkg::CHAR_W-1:0] sym_a, sym_b);
      int len, kind, k, u, p;
      line_buf.delete();
      len = board.eff_len();
      if ($urandom_range(0, 6) == 0) begin
         repeat (n) line_buf.push_back(lpmc_pkg::CHAR_W'($urandom_range(0, 255)));
         return;
      end
      while (line_buf.size() < n) begin
         kind = $urandom_range(0, 5);
         if (kind <= 1) begin
            k = $urandom_range(0, len - 1);
            for (int j = 0; j < len; j++)
               line_buf.push_back((kind == 1 && j == k) ? ~board.pat_char(j)
                                                        : board.pat_char(j));
         end else begin
            line_buf.push_back($urandom_range(0, 1) ? sym_a : sym_b);
         end
      end
      while (line_buf.size() > n) void'(line_buf.pop_back());
      kind = $urandom_range(0, 9);
      if (n < 2) begin
         if (kind < 3) line_buf[0] = lpmc_pkg::CHAR_UNDERSCORE;
         else if (kind < 6) line_buf[0] = lpmc_pkg::CHAR_PIPE;
      end else begin
         u = $urandom_range(0, (n - 2 < 4) ? n - 2 : 4);
         p = $urandom_range(u + 1, (u + 6 < n - 1) ? u + 6 : n - 1);
         if (kind <= 6) begin
            line_buf[u] = lpmc_pkg::CHAR_UNDERSCORE;
            line_buf[p] = lpmc_pkg::CHAR_PIPE;
         end else if (kind == 7) begin
            // marks swapped: pipe first, so the header check fails
            line_buf[u] = lpmc_pkg::CHAR_PIPE;
            line_buf[p] = lpmc_pkg::CHAR_UNDERSCORE;
         end else if (kind == 8) begin
            line_buf[p] = $urandom_range(0, 1) ? lpmc_pkg::CHAR_UNDERSCORE
                                               : lpmc_pkg::CHAR_PIPE;
         end
      end
   endtask

   // One setting of the pattern registers, then a stretch of random lines.
   task automatic run_phase(input int ph);
      logic [lpmc_pkg::LENGTH_W-1:0] len_val;
      logic [lpmc_pkg::CHAR_W-1:0] sym_a, sym_b;
      logic [lpmc_pkg::CSR_DATA_W-1:0] chars [lpmc_pkg::PAT_REG_COUNT];
      lpmc_pkg::csr_reg_type all_regs [5];
      int sent, n;
      all_regs = '{lpmc_pkg::REG_PATTERN_LENGTH, lpmc_pkg::REG_PATTERN_CHARS_0,
                   lpmc_pkg::REG_PATTERN_CHARS_1, lpmc_pkg::REG_PATTERN_CHARS_2,
                   lpmc_pkg::REG_PATTERN_CHARS_3};
      case (ph % 8)
         0: len_val = 6'd1;
         1: len_val = 6'd32;
         2: len_val = 6'd0;                      // reads as one
         3: len_val = 6'd63;                     // clamps to the full window
         4: len_val = 6'd2;
         5: len_val = lpmc_pkg::LENGTH_W'($urandom_range(3, 8));
         6: len_val = lpmc_pkg::LENGTH_W'($urandom_range(9, 31));
         default: len_val = lpmc_pkg::LENGTH_W'($urandom_range(33, 62));
      endcase
      sym_a = lpmc_pkg::CHAR_W'($urandom_range(0, 255));
      sym_b = lpmc_pkg::CHAR_W'($urandom_range(0, 255));
      if (ph % 8 == 3) begin
         sym_a = 8'h00;
         sym_b = 8'hFF;
      end
      foreach (chars[r])
         for (int k = 0; k < 8; k++)
            chars[r][k*8 +: 8] = ($urandom_range(0, 3) == 0) ? sym_b : sym_a;
      if (ph % 8 == 1) begin
         // all-ones pattern over all-ones text: heavy overlapping matches
         sym_a = '1;
         sym_b = '1;
         foreach (chars[r]) chars[r] = '1;
      end
      drain_lines();
      csr_write(SPARE_REG, {$urandom, $urandom});
      csr_write(lpmc_pkg::REG_PATTERN_LENGTH, {$urandom, 26'($urandom), len_val});
      csr_write(lpmc_pkg::REG_PATTERN_CHARS_0, chars[0]);
      csr_write(lpmc_pkg::REG_PATTERN_CHARS_1, chars[1]);
      csr_write(lpmc_pkg::REG_PATTERN_CHARS_2, chars[2]);
      csr_write(lpmc_pkg::REG_PATTERN_CHARS_3, chars[3]);
      foreach (all_regs[i]) csr_check(all_regs[i]);
      sent = 0;
      while (sent < PHASE_WORDS) begin
         n = (board.eff_len() > 8) ? $urandom_range(1, 80) : $urandom_range(1, 48);
         compose_line(n, sym_a, sym_b);
         send_line();
         sent += n;
      end
   endtask

   // One line past the offset limit: every fill character matches, so the
   // count saturates, and the pipe lands on the held last offset.
   task automatic run_long_lines();
      drain_lines();
      csr_write(lpmc_pkg::REG_PATTERN_LENGTH, lpmc_pkg::CSR_DATA_W'(1));
      csr_write(lpmc_pkg::REG_PATTERN_CHARS_0, {$urandom, 24'($urandom), CHAR_FILL});
      line_buf.delete();
      repeat (1030) line_buf.push_back(CHAR_FILL);
      line_buf[3] = lpmc_pkg::CHAR_UNDERSCORE;
      line_buf[1028] = lpmc_pkg::CHAR_PIPE;
      send_line();
   endtask

   initial begin
      board = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed lines on the reset setting: one-character pattern of 0x00.
      line_buf = '{8'h00, lpmc_pkg::CHAR_UNDERSCORE, 8'h00, lpmc_pkg::CHAR_PIPE, 8'h00};
      send_line();
      line_buf = '{lpmc_pkg::CHAR_PIPE, lpmc_pkg::CHAR_UNDERSCORE, 8'hFF}; // wrong order
      send_line();
      line_buf = '{8'h00};                                 // shortest line, no marks
      send_line();
      line_buf = '{lpmc_pkg::CHAR_UNDERSCORE, 8'hFF, 8'hFF, 8'h00};  // pipe missing
      send_line();
      line_buf = '{lpmc_pkg::CHAR_UNDERSCORE, lpmc_pkg::CHAR_PIPE, 8'hFF, 8'h00, 8'h00,
                   lpmc_pkg::CHAR_PIPE, lpmc_pkg::CHAR_UNDERSCORE};  // later marks ignored
      send_line();
      line_buf = '{lpmc_pkg::CHAR_PIPE};
      send_line();

      for (int ph = 0; ph < PHASES; ph++) run_phase(ph);
      run_long_lines();

      drain_lines();
      repeat (8) @(posedge clock);
      if (board.mismatches == 0 && reg_mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
